>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks shared by the translation buffer modules. Each
// check is gated off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// check that a property holds at every clock edge
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that a condition is never true at a clock edge
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

>>> sv/tlb_pkg.sv
// ----------------------------------------------------------------------------
// tlb_pkg
// Field widths, operation and status codes, and the command and status
// bundles passed between the translation buffer controller and datapath.
// ----------------------------------------------------------------------------
package tlb_pkg;

  // field widths
  localparam int OP_W    = 2;
  localparam int PID_W   = 16;
  localparam int PAGE_W  = 16;
  localparam int FRAME_W = 24;
  localparam int STAMP_W = 32;
  localparam int STAT_W  = 3;
  localparam int CFG_W   = 5;

  // default entry count and reset value of the active-entry register
  localparam int                 ENTRIES_DEF = 16;
  localparam logic [CFG_W-1:0]   CFG_RESET   = 5'd16;

  // operation codes
  localparam logic [OP_W-1:0] OP_LOOKUP    = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT    = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH_ALL = 2'd2;
  localparam logic [OP_W-1:0] OP_FLUSH_PID = 2'd3;

  // result status codes
  localparam logic [STAT_W-1:0] ST_DONE  = 3'd0;
  localparam logic [STAT_W-1:0] ST_MISS  = 3'd1;
  localparam logic [STAT_W-1:0] ST_FREE  = 3'd2;
  localparam logic [STAT_W-1:0] ST_EVICT = 3'd3;
  localparam logic [STAT_W-1:0] ST_DUP   = 3'd4;

  // controller to datapath commands
  typedef struct packed {
    logic accept;     // latch the incoming word and reset the trackers
    logic flush_all;  // clear every valid bit
    logic scan;       // issue a read at the scan index and advance it
    logic write;      // commit the chosen entry
    logic done;       // register the result word
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_last;  // scan index sits on the last entry to read
  } dp_stat_t;

endpackage

>>> sv/tlb_lru_pid_tagged.sv
// ----------------------------------------------------------------------------
// tlb_lru_pid_tagged
// Fully associative translation buffer tagged by process id and page, with
// least-recently-used replacement and whole or per-process flush.
// ----------------------------------------------------------------------------
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------------------
//   input    | start, busy          | in_opcode, in_process_id,
//            |                      | in_page_number, in_frame_address
//   result   | out_valid (1 cycle)  | out_hit, out_translation, out_status
//   config   | cfg_wr_en            | cfg_wr_data (active entries)
//
// Lookup and insert scan the clamped active entry count, one entry read per
// cycle through the single read port, then drain, write and result. Flush by
// process scans all ENTRIES; flush all goes straight to the result. No new
// word is accepted until the result of the last one is issued.
// The result word is on the out_ ports for one cycle, from the edge at which
// busy falls; the receiver cannot stall it. Reset is synchronous: valid bits
// and access clock clear, active count returns to 16.
// ----------------------------------------------------------------------------
module tlb_lru_pid_tagged import tlb_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [CFG_W-1:0]   cfg_wr_data,
  input  logic               start,
  output logic               busy,
  input  logic [OP_W-1:0]    in_opcode,
  input  logic [PID_W-1:0]   in_process_id,
  input  logic [PAGE_W-1:0]  in_page_number,
  input  logic [FRAME_W-1:0] in_frame_address,
  output logic               out_valid,
  output logic               out_hit,
  output logic [FRAME_W-1:0] out_translation,
  output logic [STAT_W-1:0]  out_status
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencer
  tlb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (in_opcode),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  // entry storage and scan logic
  tlb_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_opcode        (in_opcode),
    .in_process_id    (in_process_id),
    .in_page_number   (in_page_number),
    .in_frame_address (in_frame_address),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_hit          (out_hit),
    .out_translation  (out_translation),
    .out_status       (out_status)
  );

endmodule

>>> sv/tlb_ram.sv
// ----------------------------------------------------------------------------
// tlb_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module tlb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/tlb_ctrl.sv
// ----------------------------------------------------------------------------
// tlb_ctrl
// Sequencer for the translation buffer: accept a word, scan the entries,
// commit the chosen entry and issue the result word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tlb_ctrl import tlb_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [OP_W-1:0] in_opcode,
  input  dp_stat_t        stat,
  output ctrl_cmd_t       cmd,
  output logic            busy
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       accept;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.accept    = accept;
    cmd.flush_all = accept && (in_opcode == OP_FLUSH_ALL);
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_opcode == OP_FLUSH_ALL) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.done  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ASSERT_CLK(a_ctrl_accept_busy, (start && !busy) |=> busy, "busy low after accepted word")
  `ASSERT_CLK(a_ctrl_drain_write, (state_r == S_DRAIN) |=> (state_r == S_WRITE), "drain did not write")
  `ASSERT_CLK(a_ctrl_done_idle, (state_r == S_DONE) |=> !busy, "still busy after result")

endmodule

>>> sv/tlb_dp.sv
// ----------------------------------------------------------------------------
// tlb_dp
// Translation buffer datapath: entry memory, valid bits, access clock,
// scan trackers for match, free slot and oldest entry, and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tlb_dp import tlb_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [CFG_W-1:0]   cfg_wr_data,
  input  logic [OP_W-1:0]    in_opcode,
  input  logic [PID_W-1:0]   in_process_id,
  input  logic [PAGE_W-1:0]  in_page_number,
  input  logic [FRAME_W-1:0] in_frame_address,
  input  ctrl_cmd_t          cmd,
  output dp_stat_t           stat,
  output logic               out_valid,
  output logic               out_hit,
  output logic [FRAME_W-1:0] out_translation,
  output logic [STAT_W-1:0]  out_status
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int NW = (CW > CFG_W) ? CW : CFG_W;
  localparam int EW = PID_W + PAGE_W + FRAME_W + STAMP_W;

  // configuration and control state
  logic [CFG_W-1:0]   active_r;
  logic [ENTRIES-1:0] valid_r;
  logic [STAMP_W-1:0] clock_r;

  // latched input word
  logic [OP_W-1:0]    op_r;
  logic [PID_W-1:0]   pid_r;
  logic [PAGE_W-1:0]  page_r;
  logic [FRAME_W-1:0] frame_r;

  // scan pointer and compare stage
  logic [IW-1:0]      scan_idx_r;
  logic [IW-1:0]      last_idx_r;
  logic [IW-1:0]      last_nxt;
  logic               cmp_vld_r;
  logic [IW-1:0]      cmp_idx_r;

  // trackers
  logic               match_found_r;
  logic [IW-1:0]      match_idx_r;
  logic [FRAME_W-1:0] match_frame_r;
  logic               free_found_r;
  logic [IW-1:0]      free_idx_r;
  logic [STAMP_W-1:0] oldest_r;
  logic [IW-1:0]      victim_idx_r;

  // result register
  logic               out_valid_r;
  logic               out_hit_r;
  logic [FRAME_W-1:0] out_trans_r;
  logic [STAT_W-1:0]  out_status_r;

  // memory ports
  logic [EW-1:0]      ram_rdata;
  logic [EW-1:0]      ram_wdata;
  logic               ram_we;

  // compare stage signals
  logic [NW-1:0]      act_ext;
  logic [NW-1:0]      n_use;
  logic [PID_W-1:0]   rd_pid;
  logic [PAGE_W-1:0]  rd_page;
  logic [FRAME_W-1:0] rd_frame;
  logic [STAMP_W-1:0] rd_stamp;
  logic [STAMP_W-1:0] age;
  logic               ent_v;
  logic               pid_eq;
  logic               key_hit;

  // write stage signals
  logic               wr_ok;
  logic [IW-1:0]      wr_idx;
  logic [FRAME_W-1:0] wr_frame;
  logic [STAT_W-1:0]  res_status;

  // clamp the active count to 1..ENTRIES and pick the last scan index
  always_comb begin
    act_ext = NW'(active_r);
    if (act_ext == '0) begin
      n_use = NW'(1);
    end else if (act_ext > NW'(ENTRIES)) begin
      n_use = NW'(ENTRIES);
    end else begin
      n_use = act_ext;
    end
    if (in_opcode == OP_FLUSH_PID) begin
      last_nxt = IW'(ENTRIES - 1);
    end else begin
      last_nxt = IW'(n_use - NW'(1));
    end
  end

  assign stat.scan_last = (scan_idx_r == last_idx_r);

  // unpack the entry read in the previous cycle
  assign rd_pid   = ram_rdata[EW-1 -: PID_W];
  assign rd_page  = ram_rdata[EW-PID_W-1 -: PAGE_W];
  assign rd_frame = ram_rdata[STAMP_W +: FRAME_W];
  assign rd_stamp = ram_rdata[STAMP_W-1:0];
  assign ent_v    = valid_r[cmp_idx_r];
  assign pid_eq   = (rd_pid == pid_r);
  assign key_hit  = ent_v && pid_eq && (rd_page == page_r);
  assign age      = clock_r - rd_stamp;

  // choose the entry to commit and the result status
  always_comb begin
    wr_ok      = 1'b0;
    wr_idx     = match_idx_r;
    wr_frame   = frame_r;
    res_status = ST_DONE;
    unique case (op_r)
      OP_LOOKUP: begin
        wr_ok      = match_found_r;
        wr_frame   = match_frame_r;
        res_status = match_found_r ? ST_DONE : ST_MISS;
      end
      OP_INSERT: begin
        wr_ok = 1'b1;
        if (match_found_r) begin
          res_status = ST_DUP;
        end else if (free_found_r) begin
          wr_idx     = free_idx_r;
          res_status = ST_FREE;
        end else begin
          wr_idx     = victim_idx_r;
          res_status = ST_EVICT;
        end
      end
      OP_FLUSH_ALL, OP_FLUSH_PID: begin
        res_status = ST_DONE;
      end
      default: begin
        res_status = ST_DONE;
      end
    endcase
  end

  assign ram_we    = cmd.write && wr_ok;
  assign ram_wdata = {pid_r, page_r, wr_frame, clock_r};

  tlb_ram #(
    .WIDTH (EW),
    .DEPTH (ENTRIES),
    .AW    (IW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wr_idx),
    .wr_data (ram_wdata),
    .rd_en   (cmd.scan),
    .rd_addr (scan_idx_r),
    .rd_data (ram_rdata)
  );

  // control state: config, valid bits, clock, trackers, result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r      <= CFG_RESET;
      valid_r       <= '0;
      clock_r       <= '0;
      cmp_vld_r     <= 1'b0;
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        active_r <= cfg_wr_data;
      end
      // advance the access clock on a lookup
      if (cmd.accept && (in_opcode == OP_LOOKUP)) begin
        clock_r <= clock_r + STAMP_W'(1);
      end
      cmp_vld_r <= cmd.scan;
      if (cmd.accept) begin
        match_found_r <= 1'b0;
        free_found_r  <= 1'b0;
      end else if (cmp_vld_r) begin
        if (key_hit) begin
          match_found_r <= 1'b1;
        end
        if (!ent_v) begin
          free_found_r <= 1'b1;
        end
      end
      // valid bits: flush all, per-process clear, commit
      if (cmd.flush_all) begin
        valid_r <= '0;
      end else begin
        if (cmp_vld_r && (op_r == OP_FLUSH_PID) && ent_v && pid_eq) begin
          valid_r[cmp_idx_r] <= 1'b0;
        end
        if (ram_we) begin
          valid_r[wr_idx] <= 1'b1;
        end
      end
      out_valid_r <= cmd.done;
    end
  end

  // payload: latched word, scan pointer, tracker indexes, result fields
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r       <= in_opcode;
      pid_r      <= in_process_id;
      page_r     <= in_page_number;
      frame_r    <= in_frame_address;
      last_idx_r <= last_nxt;
      scan_idx_r <= '0;
    end else if (cmd.scan) begin
      scan_idx_r <= scan_idx_r + IW'(1);
    end
    cmp_idx_r <= scan_idx_r;
    if (cmp_vld_r && !cmd.accept) begin
      // keep the lowest matching entry
      if (key_hit && !match_found_r) begin
        match_idx_r   <= cmp_idx_r;
        match_frame_r <= rd_frame;
      end
      // keep the lowest free entry
      if (!ent_v && !free_found_r) begin
        free_idx_r <= cmp_idx_r;
      end
      // keep the oldest entry, lowest index on a tie
      if ((cmp_idx_r == '0) || (age > oldest_r)) begin
        oldest_r     <= age;
        victim_idx_r <= cmp_idx_r;
      end
    end
    if (cmd.done) begin
      out_hit_r    <= (op_r == OP_LOOKUP) && match_found_r;
      out_trans_r  <= ((op_r == OP_LOOKUP) && match_found_r) ? match_frame_r : '0;
      out_status_r <= res_status;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_translation = out_trans_r;
  assign out_status      = out_status_r;

  `ASSERT_CLK(a_dp_out_single, out_valid_r |=> !out_valid_r, "result strobe held two cycles")
  `ASSERT_NEVER(a_dp_cmp_accept, cmp_vld_r && cmd.accept, "compare active at accept")
  `ASSERT_CLK(a_dp_scan_bound, cmd.scan |-> (scan_idx_r <= last_idx_r), "scan past last entry")

endmodule

>>> bench/tlb_scoreboard_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tlb_scoreboard_pkg
// Scoreboard for the translation buffer bench. It keeps its own copy of the
// buffer entries, the access clock and the active count, predicts the result
// word of each accepted command and compares arriving words in order.
// ----------------------------------------------------------------------------
package tlb_scoreboard_pkg;
  import tlb_pkg::*;

  // one result word as seen on the out_ ports
  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] translation;
    logic [STAT_W-1:0]  status;
  } tlb_word_t;

  class tlb_scoreboard;
    bit                 valid_q   [ENTRIES_DEF];
    logic [PID_W-1:0]   pid_q     [ENTRIES_DEF];
    logic [PAGE_W-1:0]  page_q    [ENTRIES_DEF];
    logic [FRAME_W-1:0] frame_q   [ENTRIES_DEF];
    logic [STAMP_W-1:0] stamp_q   [ENTRIES_DEF];
    logic [STAMP_W-1:0] access_clock;
    logic [CFG_W-1:0]   active_cfg;
    tlb_word_t          result_words_q[$];
    int                 mismatches;

    function new();
      active_cfg   = CFG_RESET;
      access_clock = '0;
      mismatches   = 0;
      for (int i = 0; i < ENTRIES_DEF; i++) clear_entry(i);
    endfunction

    function void write_active(logic [CFG_W-1:0] value);
      active_cfg = value;
    endfunction

    // clamp the register to 1..ENTRIES
    function int entries_in_use();
      int n;
      n = int'(active_cfg);
      if (n < 1) n = 1;
      if (n > ENTRIES_DEF) n = ENTRIES_DEF;
      return n;
    endfunction

    // lowest active entry that matches, or -1
    function int find_entry(logic [PID_W-1:0] pid, logic [PAGE_W-1:0] page);
      int n;
      n = entries_in_use();
      for (int i = 0; i < n; i++)
        if (valid_q[i] && pid_q[i] == pid && page_q[i] == page) return i;
      return -1;
    endfunction

    function void clear_entry(int i);
      valid_q[i] = 1'b0;
      pid_q[i]   = '0;
      page_q[i]  = '0;
      frame_q[i] = '0;
      stamp_q[i] = '0;
    endfunction

    function void fill_entry(int i, logic [PID_W-1:0] pid, logic [PAGE_W-1:0] page,
                             logic [FRAME_W-1:0] frame);
      valid_q[i] = 1'b1;
      pid_q[i]   = pid;
      page_q[i]  = page;
      frame_q[i] = frame;
      stamp_q[i] = access_clock;
    endfunction

    // advance the model by one accepted command and queue its result word
    function void note_command(logic [OP_W-1:0] op, logic [PID_W-1:0] pid,
                               logic [PAGE_W-1:0] page, logic [FRAME_W-1:0] frame);
      tlb_word_t          w;
      int                 idx;
      int                 n;
      int                 victim;
      logic [STAMP_W-1:0] age;
      logic [STAMP_W-1:0] oldest;
      bit                 placed;
      w      = '0;
      w.status = ST_DONE;
      n      = entries_in_use();
      victim = 0;
      oldest = '0;
      placed = 1'b0;
      case (op)
        OP_LOOKUP: begin
          access_clock = access_clock + STAMP_W'(1);
          idx = find_entry(pid, page);
          if (idx >= 0) begin
            stamp_q[idx]  = access_clock;
            w.hit         = 1'b1;
            w.translation = frame_q[idx];
          end else begin
            w.status = ST_MISS;
          end
        end
        OP_INSERT: begin
          idx = find_entry(pid, page);
          if (idx >= 0) begin
            fill_entry(idx, pid, page, frame);
            w.status = ST_DUP;
          end else begin
            // take the lowest free entry first
            for (int i = 0; i < n && !placed; i++) begin
              if (!valid_q[i]) begin
                fill_entry(i, pid, page, frame);
                w.status = ST_FREE;
                placed   = 1'b1;
              end
            end
            // otherwise evict the oldest, lowest index on a tie
            if (!placed) begin
              for (int i = 0; i < n; i++) begin
                age = access_clock - stamp_q[i];
                if (i == 0 || age > oldest) begin
                  oldest = age;
                  victim = i;
                end
              end
              fill_entry(victim, pid, page, frame);
              w.status = ST_EVICT;
            end
          end
        end
        OP_FLUSH_ALL: begin
          for (int i = 0; i < ENTRIES_DEF; i++) clear_entry(i);
        end
        default: begin
          for (int i = 0; i < ENTRIES_DEF; i++)
            if (valid_q[i] && pid_q[i] == pid) clear_entry(i);
        end
      endcase
      result_words_q.push_back(w);
    endfunction

    // compare an arriving word with the oldest prediction
    function void check_word(logic hit, logic [FRAME_W-1:0] translation,
                             logic [STAT_W-1:0] status);
      tlb_word_t w;
      if (result_words_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: hit %0b translation %06h status %0d",
                   hit, translation, status);
        return;
      end
      w = result_words_q.pop_front();
      if (hit !== w.hit || translation !== w.translation || status !== w.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result mismatch: expected hit %0b translation %06h status %0d,",
                    " got hit %0b translation %06h status %0d"},
                   w.hit, w.translation, w.status, hit, translation, status);
      end
    endfunction

    function int pending();
      return result_words_q.size();
    endfunction
  endclass

endpackage

>>> bench/tb_tlb_lru_pid_tagged.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tlb_lru_pid_tagged
// Self-checking bench for the translation buffer. A directed sequence covers
// field extremes, duplicates, per-process and full flush, LRU eviction and
// the tie case; random phases then run over several active entry counts with
// a small key pool so lookups hit and inserts collide and evict.
// ----------------------------------------------------------------------------
module tb_tlb_lru_pid_tagged;
  import tlb_pkg::*;
  import tlb_scoreboard_pkg::*;

  localparam int RANDOM_WORDS = 1150;
  localparam int NUM_PHASES   = 12;
  localparam int CYCLE_LIMIT  = 600000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]   cfg_wr_data = '0;
  logic               start = 1'b0;
  logic               busy;
  logic [OP_W-1:0]    in_opcode = OP_LOOKUP;
  logic [PID_W-1:0]   in_process_id = '0;
  logic [PAGE_W-1:0]  in_page_number = '0;
  logic [FRAME_W-1:0] in_frame_address = '0;
  logic               out_valid;
  logic               out_hit;
  logic [FRAME_W-1:0] out_translation;
  logic [STAT_W-1:0]  out_status;

  int unsigned        cycle_count = 0;
  logic [PID_W-1:0]   pid_pool  [4];
  logic [PAGE_W-1:0]  page_pool [8];
  logic [CFG_W-1:0]   phase_cfg [NUM_PHASES];

  tlb_scoreboard sb = new();

  tlb_lru_pid_tagged u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_process_id    (in_process_id),
    .in_page_number   (in_page_number),
    .in_frame_address (in_frame_address),
    .out_valid        (out_valid),
    .out_hit          (out_hit),
    .out_translation  (out_translation),
    .out_status       (out_status)
  );

  // free-running clock
  initial begin
    forever #5 clk = ~clk;
  end

  // bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_tlb_lru_pid_tagged: FAIL");
      $finish;
    end
  end

  // check each result word at the edge that ends its cycle
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_word(out_hit, out_translation, out_status);
  end

  // present a command word and hold it until accepted
  task automatic send_command(logic [OP_W-1:0] op, logic [PID_W-1:0] pid,
                              logic [PAGE_W-1:0] page, logic [FRAME_W-1:0] frame);
    start            <= 1'b1;
    in_opcode        <= op;
    in_process_id    <= pid;
    in_page_number   <= page;
    in_frame_address <= frame;
    do @(posedge clk); while (busy);
    sb.note_command(op, pid, page, frame);
  endtask

  // drop start and idle, or hold off until every result word is back
  task automatic pace(bit drain);
    int r;
    int gap;
    r = $urandom_range(0, 99);
    if (drain) begin
      start <= 1'b0;
      while (sb.pending() != 0 || busy) @(posedge clk);
    end else begin
      if (r < 60)      gap = 0;
      else if (r < 90) gap = $urandom_range(1, 3);
      else if (r < 98) gap = $urandom_range(4, 10);
      else             gap = $urandom_range(20, 40);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic issue(logic [OP_W-1:0] op, logic [PID_W-1:0] pid,
                       logic [PAGE_W-1:0] page, logic [FRAME_W-1:0] frame);
    send_command(op, pid, page, frame);
    pace(1'b0);
  endtask

  // write the active count while idle
  task automatic write_active(logic [CFG_W-1:0] value);
    pace(1'b1);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.write_active(value);
  endtask

  // one random phase: mostly pooled keys, some fully random words
  task automatic run_random_phase(int words);
    int               r;
    logic [OP_W-1:0]  op;
    logic [PID_W-1:0] pid;
    logic [PAGE_W-1:0] page;
    for (int i = 0; i < 4; i++) pid_pool[i] = PID_W'($urandom_range(0, 16'hFFFF));
    for (int i = 0; i < 8; i++) page_pool[i] = PAGE_W'($urandom_range(0, 16'hFFFF));
    for (int k = 0; k < words; k++) begin
      r = $urandom_range(0, 99);
      if (r < 45)      op = OP_LOOKUP;
      else if (r < 82) op = OP_INSERT;
      else if (r < 97) op = OP_FLUSH_PID;
      else             op = OP_FLUSH_ALL;
      if ($urandom_range(0, 99) < 85) begin
        pid  = pid_pool[$urandom_range(0, 3)];
        page = page_pool[$urandom_range(0, 7)];
      end else begin
        pid  = PID_W'($urandom_range(0, 16'hFFFF));
        page = PAGE_W'($urandom_range(0, 16'hFFFF));
      end
      send_command(op, pid, page, FRAME_W'($urandom_range(0, 24'hFFFFFF)));
      pace(k == words / 2 || $urandom_range(0, 99) == 0);
    end
  endtask

  initial begin
    // hold reset, then release on an edge
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, duplicate insert, flushes at the reset count
    issue(OP_LOOKUP,    16'h0000, 16'h0000, 24'h000000);
    issue(OP_INSERT,    16'h0000, 16'h0000, 24'h000000);
    issue(OP_INSERT,    16'hFFFF, 16'hFFFF, 24'hFFFFFF);
    issue(OP_LOOKUP,    16'h0000, 16'h0000, 24'hFFFFFF);
    issue(OP_LOOKUP,    16'hFFFF, 16'hFFFF, 24'h000000);
    issue(OP_INSERT,    16'h0000, 16'h0000, 24'h5A5A5A);
    issue(OP_LOOKUP,    16'h0000, 16'h0000, 24'h000000);
    issue(OP_INSERT,    16'hFFFF, 16'h0000, 24'hA5A5A5);
    issue(OP_FLUSH_PID, 16'hFFFF, 16'h1234, 24'h000000);
    issue(OP_LOOKUP,    16'hFFFF, 16'hFFFF, 24'h000000);
    issue(OP_LOOKUP,    16'h0000, 16'h0000, 24'h000000);
    issue(OP_FLUSH_ALL, 16'h0000, 16'h0000, 24'h000000);
    issue(OP_LOOKUP,    16'h0000, 16'h0000, 24'h000000);

    // directed: LRU eviction and the equal-age tie with two entries
    write_active(5'd2);
    issue(OP_INSERT,    16'h0001, 16'h0010, 24'h111111);
    issue(OP_INSERT,    16'h0002, 16'h0020, 24'h222222);
    issue(OP_LOOKUP,    16'h0001, 16'h0010, 24'h000000);
    issue(OP_INSERT,    16'h0003, 16'h0030, 24'h333333);
    issue(OP_LOOKUP,    16'h0002, 16'h0020, 24'h000000);
    issue(OP_LOOKUP,    16'h0001, 16'h0010, 24'h000000);
    issue(OP_LOOKUP,    16'h0003, 16'h0030, 24'h000000);
    issue(OP_FLUSH_ALL, 16'h0000, 16'h0000, 24'h000000);
    issue(OP_INSERT,    16'h0004, 16'h0040, 24'h444444);
    issue(OP_INSERT,    16'h0005, 16'h0050, 24'h555555);
    issue(OP_INSERT,    16'h0006, 16'h0060, 24'h666666);
    issue(OP_LOOKUP,    16'h0004, 16'h0040, 24'h000000);

    // random phases over several active counts, out-of-range ones too
    phase_cfg[0]  = 5'd16;
    phase_cfg[1]  = 5'd1;
    phase_cfg[2]  = 5'd0;
    phase_cfg[3]  = 5'd31;
    phase_cfg[4]  = 5'd3;
    phase_cfg[5]  = 5'd8;
    phase_cfg[6]  = 5'd16;
    phase_cfg[7]  = 5'd5;
    phase_cfg[8]  = CFG_W'($urandom_range(1, 16));
    phase_cfg[9]  = CFG_W'($urandom_range(17, 31));
    phase_cfg[10] = 5'd2;
    phase_cfg[11] = 5'd12;
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_active(phase_cfg[p]);
      run_random_phase(RANDOM_WORDS / NUM_PHASES);
    end

    // drain and let the block settle
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_tlb_lru_pid_tagged: PASS");
    end else begin
      $display("tb_tlb_lru_pid_tagged: FAIL");
    end
    $finish;
  end

endmodule
